/* sv/mkc_pkg.sv */
// Package for the mini key counter with SHA-256 check.
// Holds the alphabet, SHA-256 constants and shared command/status types.
`default_nettype none
package mkc_pkg;

  localparam int MaxKeyChars   = 30;
  localparam int AlphabetSize  = 58;
  localparam int ShortKeyChars = 22;
  localparam logic [7:0] TailChar = 8'h3F;
  localparam logic [7:0] PadByte  = 8'h80;

  localparam logic [0:0] CfgKeyIsLong   = 1'b0;
  localparam logic [0:0] CfgCheckEnable = 1'b1;

  // character for a digit, zero outside the alphabet
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    begin
      c = 8'h00;
      if (d < 6'd9)       c = 8'h31 + {2'b00, d};
      else if (d < 6'd17) c = 8'h41 + {2'b00, d - 6'd9};
      else if (d < 6'd22) c = 8'h4A + {2'b00, d - 6'd17};
      else if (d < 6'd33) c = 8'h50 + {2'b00, d - 6'd22};
      else if (d < 6'd44) c = 8'h61 + {2'b00, d - 6'd33};
      else if (d < 6'd58) c = 8'h6D + {2'b00, d - 6'd44};
      return c;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  localparam logic [255:0] InitH = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  typedef struct packed {
    logic start;   // latch candidate block, begin rounds
    logic round;   // run one compression round
    logic advance; // step counter by one
  } mkc_cmd_t;

  typedef struct packed {
    logic last_round;
    logic passed;
  } mkc_sts_t;

endpackage
`default_nettype wire

/* sv/mkc_datapath.sv */
// Datapath: digit store, block builder, one-round-per-cycle SHA-256 core,
// carry-ripple counter advance. Depends on mkc_pkg.
`default_nettype none
module mkc_datapath #(
  parameter int MAX_KEY_CHARS = mkc_pkg::MaxKeyChars,
  parameter int ALPHABET_SIZE = mkc_pkg::AlphabetSize
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           key_is_long_i,
  input  wire logic           load_i,
  input  wire logic [4:0]     digit_position_i,
  input  wire logic [5:0]     digit_value_i,
  input  wire mkc_pkg::mkc_cmd_t cmd_i,
  output mkc_pkg::mkc_sts_t   sts_o,
  output logic [239:0]        chars_o,
  output logic                wrapped_o
);
  import mkc_pkg::*;

  localparam int TopDigit = ALPHABET_SIZE - 1;

  logic [5:0] digits_q [MAX_KEY_CHARS];
  logic [5:0] digits_d [MAX_KEY_CHARS];
  logic       wrap_d;
  logic [7:0] chr [MAX_KEY_CHARS];
  logic [239:0] chars_d;
  logic [239:0] chars_q;
  logic [511:0] blk;
  logic [511:0] w_q;
  logic [255:0] v_q;
  logic [5:0]   rnd_q;
  logic [31:0]  a, b, c, e, f, g, h, t1, t2, s0, s1, wn;
  logic [31:0]  wi;

  always_comb begin
    for (int i = 0; i < MAX_KEY_CHARS; i++) begin
      if (i >= ShortKeyChars && !key_is_long_i) chr[i] = 8'h00;
      else if ({1'b0, digits_q[i]} >= 7'(ALPHABET_SIZE)) chr[i] = 8'h00;
      else chr[i] = digit_char(digits_q[i]);
    end
    chars_d = '0;
    for (int i = 0; i < MAX_KEY_CHARS; i++) chars_d[239 - 8*i -: 8] = chr[i];
    blk = '0;
    blk[511 -: 240] = chars_d;
    if (key_is_long_i) begin
      blk[511 - 8*MAX_KEY_CHARS -: 16] = {TailChar, PadByte};
      blk[15:0] = 16'((MAX_KEY_CHARS + 1) * 8);
    end else begin
      blk[511 - 8*ShortKeyChars -: 16] = {TailChar, PadByte};
      blk[15:0] = 16'((ShortKeyChars + 1) * 8);
    end
  end

  // counter advance: ripple from the last digit in use
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < MAX_KEY_CHARS; i++) digits_d[i] = digits_q[i];
    for (int i = MAX_KEY_CHARS - 1; i >= 0; i--) begin
      if (carry && (key_is_long_i || i < ShortKeyChars)) begin
        if (digits_q[i] < 6'(TopDigit)) begin
          digits_d[i] = digits_q[i] + 6'd1;
          carry = 1'b0;
        end else begin
          digits_d[i] = '0;
        end
      end
    end
    wrap_d = carry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KEY_CHARS; i++) digits_q[i] <= '0;
    end else if (load_i) begin
      if (32'(digit_position_i) < MAX_KEY_CHARS)
        digits_q[digit_position_i] <= digit_value_i;
    end else if (cmd_i.advance) begin
      for (int i = 0; i < MAX_KEY_CHARS; i++) digits_q[i] <= digits_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) wrapped_o <= wrap_d;
    if (cmd_i.start) chars_q <= chars_d;
  end
  assign chars_o = chars_q;

  // SHA-256 round unit with a 16-word schedule window
  assign a = v_q[255:224]; assign b = v_q[223:192]; assign c = v_q[191:160];
  assign e = v_q[127:96];  assign f = v_q[95:64];   assign g = v_q[63:32];
  assign h = v_q[31:0];
  assign wi = w_q[511:480];
  assign s0 = {w_q[454:448], w_q[479:455]} ^ {w_q[465:448], w_q[479:466]} ^ (w_q[479:448] >> 3);
  assign s1 = {w_q[48:32], w_q[63:49]} ^ {w_q[50:32], w_q[63:51]} ^ (w_q[63:32] >> 10);
  assign wn = wi + s0 + w_q[223:192] + s1;
  assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + round_k(rnd_q) + wi;
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (cmd_i.start) begin
      rnd_q <= '0;
    end else if (cmd_i.round) begin
      rnd_q <= rnd_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q <= blk;
      v_q <= InitH;
    end else if (cmd_i.round) begin
      w_q <= {w_q[479:0], wn};
      v_q <= {t1 + t2, a, b, c, v_q[159:128] + t1, e, f, g};
    end
  end

  assign sts_o.last_round = (rnd_q == 6'd63);
  assign sts_o.passed     = ((v_q[255:224] + InitH[255:224]) >> 24) == 32'd0;

endmodule
`default_nettype wire

/* sv/mkc_ctrl.sv */
// Controller: accepts transactions, sequences 64 rounds, drives the output register.
// Depends on mkc_pkg.
`default_nettype none
module mkc_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       check_enable_i,
  input  wire logic       in_valid_i,
  input  wire logic       req_step_i,
  output logic            in_ready_o,
  output logic            load_o,
  output mkc_pkg::mkc_cmd_t cmd_o,
  input  wire mkc_pkg::mkc_sts_t sts_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            capture_o
);
  import mkc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign load_o     = accept && !req_step_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    capture_o   = 1'b0;
    ovalid_d    = ovalid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (accept && req_step_i) begin
          cmd_o.start = 1'b1;
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = StDone;
      end
      StDone: begin
        // wait for a free output register
        if (!ovalid_q || out_ready_i) begin
          cmd_o.advance = 1'b1;
          capture_o = 1'b1;
          ovalid_d = !check_enable_i || sts_i.passed;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
  assign out_valid_o = ovalid_q;

endmodule
`default_nettype wire

/* sv/minikey_counter_sha256_check.sv */
// Mini key counter with SHA-256 check: top level.
// A step runs in order: accept, 64 SHA-256
// rounds (one round per cycle through the single round unit), and a finish step that
// waits for a free output register, advances the counter and fills the output register.
// Loads are taken 1 per cycle while idle; a step is accepted only once the last step is done.
// Asynchronous active-low reset clears the digits to zero, key_is_long to 0, check_enable to 1.
`default_nettype none
module minikey_counter_sha256_check #(
  parameter int MAX_KEY_CHARS = mkc_pkg::MaxKeyChars,
  parameter int ALPHABET_SIZE = mkc_pkg::AlphabetSize
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [0:0]   cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,  // digit_position[4:0], digit_value[10:5], zeros
  input  wire logic         s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [247:0]      m_axis_tdata   // chars_first, chars_second, chars_third,
                                           // chars_fourth, check_passed, counter_wrapped
);
  import mkc_pkg::*;

  logic key_is_long_q, check_enable_q;
  mkc_cmd_t cmd;
  mkc_sts_t sts;
  logic load, capture, wrapped;
  logic [239:0] chars;
  logic [240:0] res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_is_long_q  <= 1'b0;
      check_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgKeyIsLong)   key_is_long_q  <= cfg_data_i[0];
      if (cfg_index_i == CfgCheckEnable) check_enable_q <= cfg_data_i[0];
    end
  end

  mkc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .check_enable_i (check_enable_q),
    .in_valid_i     (s_axis_tvalid),
    .req_step_i     (s_axis_tuser),
    .in_ready_o     (s_axis_tready),
    .load_o         (load),
    .cmd_o          (cmd),
    .sts_i          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .capture_o      (capture)
  );

  mkc_datapath #(.MAX_KEY_CHARS(MAX_KEY_CHARS), .ALPHABET_SIZE(ALPHABET_SIZE)) u_dp (
    .clk_i, .rst_ni,
    .key_is_long_i    (key_is_long_q),
    .load_i           (load),
    .digit_position_i (s_axis_tdata[4:0]),
    .digit_value_i    (s_axis_tdata[10:5]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .chars_o          (chars),
    .wrapped_o        (wrapped)
  );

  // output register; the wrap flag is registered in the datapath on the same
  // advance and only changes on the next advance, once this result has left
  always_ff @(posedge clk_i) begin
    if (capture) res_q <= {sts.passed, chars};
  end

  assign m_axis_tdata = {6'd0, wrapped, res_q[240],
                         res_q[47:0], res_q[111:48], res_q[175:112], res_q[239:176]};

endmodule
`default_nettype wire

/* sv/mkc_checker.sv */
// Port-level checker for the mini key counter, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module mkc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [247:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("step did not occupy the block");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("load stalled input");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[247:242] == 6'd0)
    else $error("padding bits set");
endmodule

bind minikey_counter_sha256_check mkc_checker u_mkc_checker (.*);
`default_nettype wire
